>>> sv/spct_pkg.sv
`timescale 1ns / 1ps
package spct_pkg;
	localparam logic [1:0] KIND_RECT   = 2'd0;
	localparam logic [1:0] KIND_CIRCLE = 2'd1;
	localparam logic [1:0] KIND_SEG    = 2'd2;

	localparam logic [1:0] PAIR_NONE   = 2'd0;
	localparam logic [1:0] PAIR_RC     = 2'd1;
	localparam logic [1:0] PAIR_CC     = 2'd2;
	localparam logic [1:0] PAIR_CS     = 2'd3;

	localparam int MARGIN_W    = 16;
	localparam int MARGIN_FRAC = 8;
	localparam logic [MARGIN_W-1:0] MARGIN_RESET = 16'd1280;
endpackage

>>> sv/shape_pair_collision_test.sv
`timescale 1ns / 1ps
// Channel   Direction  Handshake            Payload
// in        sink       in_valid / in_stall  a_kind a_x a_y a_w a_h b_kind b_x b_y b_w b_h
// out       source     out_valid/out_stall  hit pair_supported
// cfg       sink       cfg_we               cfg_wdata (segment_margin)
// One request per cycle while no stall holds the pipe; requests pass through stages s1..s6.
// s1 orders and sums edges, s2 takes differences, s3 forms products,
// s4 compares and splits the wide squares, s5 sums them, s6 compares.
// Stall freezes every stage only while the output stage holds a request.
// arst_n clears the valid bits and loads segment_margin with 5.0.
module shape_pair_collision_test
	import spct_pkg::*;
#(
	parameter int COORD_BITS = 24,
	parameter int FRAC_BITS  = 8
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         cfg_we,
	input  logic [MARGIN_W-1:0]          cfg_wdata,
	input  logic                         in_valid,
	output logic                         in_stall,
	input  logic [1:0]                   a_kind,
	input  logic signed [COORD_BITS-1:0] a_x,
	input  logic signed [COORD_BITS-1:0] a_y,
	input  logic signed [COORD_BITS-1:0] a_w,
	input  logic signed [COORD_BITS-1:0] a_h,
	input  logic [1:0]                   b_kind,
	input  logic signed [COORD_BITS-1:0] b_x,
	input  logic signed [COORD_BITS-1:0] b_y,
	input  logic signed [COORD_BITS-1:0] b_w,
	input  logic signed [COORD_BITS-1:0] b_h,
	output logic                         out_valid,
	input  logic                         out_stall,
	output logic                         hit,
	output logic                         pair_supported
);
	// value widths: sums of coords are held in C+3 bits, products in twice that plus 2
	localparam int VW = COORD_BITS + 3;
	localparam int PW = 2 * VW + 2;
	localparam int QW = 4 * VW + 4;
	localparam int MW = MARGIN_W + FRAC_BITS;
	// halves of a product for the split squares
	localparam int LB = PW / 2;
	localparam int HB = PW - LB;

	typedef logic signed [VW-1:0] val_t;
	typedef logic signed [PW-1:0] prod_t;
	typedef logic signed [QW-1:0] quad_t;
	typedef logic signed [HB-1:0] hpart_t;
	typedef logic signed [LB:0]   lpart_t;
	typedef logic signed [PW+1:0] pp_t;

	logic [MARGIN_W-1:0] margin_q;
	logic                adv;
	logic                v_s1, v_s2, v_s3, v_s4, v_s5, v_s6;

	// single control enable: everything moves unless output is stuck
	assign adv      = !(v_s6 && out_stall);
	assign in_stall = !adv;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			margin_q <= MARGIN_RESET;
		end else if (cfg_we) begin
			margin_q <= cfg_wdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0; v_s2 <= 1'b0; v_s3 <= 1'b0;
			v_s4 <= 1'b0; v_s5 <= 1'b0; v_s6 <= 1'b0;
		end else if (adv) begin
			v_s1 <= in_valid; v_s2 <= v_s1; v_s3 <= v_s2;
			v_s4 <= v_s3; v_s5 <= v_s4; v_s6 <= v_s5;
		end
	end

	// ---------------- stage 1: order pair, classify, edge sums
	logic [1:0] ka, kb;
	logic       swp;
	val_t       ax, ay, aw, ah, bx, by, bw, bh, mrg;
	logic [1:0] pair;
	logic [MW-1:0] mshift;

	always_comb begin
		swp = a_kind > b_kind;
		ka  = swp ? b_kind : a_kind;
		kb  = swp ? a_kind : b_kind;
		ax  = val_t'(swp ? b_x : a_x);
		ay  = val_t'(swp ? b_y : a_y);
		aw  = val_t'(swp ? b_w : a_w);
		ah  = val_t'(swp ? b_h : a_h);
		bx  = val_t'(swp ? a_x : b_x);
		by  = val_t'(swp ? a_y : b_y);
		bw  = val_t'(swp ? a_w : b_w);
		bh  = val_t'(swp ? a_h : b_h);
		mshift = MW'(margin_q) << FRAC_BITS;
		mrg = val_t'(mshift >> MARGIN_FRAC);
		priority if (ka == KIND_RECT && kb == KIND_CIRCLE)   pair = PAIR_RC;
		else if (ka == KIND_CIRCLE && kb == KIND_CIRCLE)     pair = PAIR_CC;
		else if (ka == KIND_CIRCLE && kb == KIND_SEG)        pair = PAIR_CS;
		else                                                 pair = PAIR_NONE;
	end

	logic [1:0] pair_s1;
	val_t rx0_s1, rx1_s1, ry0_s1, ry1_s1, rxe_s1, rye_s1;
	val_t cx_s1, cy_s1, r_s1, ex_s1, ey_s1, dx_s1, dy_s1, ex2_s1, ey2_s1;
	logic rect_edge_ok;
	val_t rxe, rye, rad;

	always_comb begin
		rxe = ax + aw;
		rye = ay + ah;
		unique case (pair)
			PAIR_CC: rad = aw + bw;
			PAIR_CS: rad = aw + mrg;
			default: rad = bw;
		endcase
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			pair_s1 <= pair;
			rx0_s1  <= (ax < rxe) ? ax : rxe;
			rx1_s1  <= (ax < rxe) ? rxe : ax;
			ry0_s1  <= (ay < rye) ? ay : rye;
			ry1_s1  <= (ay < rye) ? rye : ay;
			rxe_s1  <= rxe;
			rye_s1  <= rye;
			r_s1    <= rad;
			// for CC/CS: circle is a; for RC: circle is b, rect corner a
			cx_s1   <= (pair == PAIR_RC) ? bx : ax;
			cy_s1   <= (pair == PAIR_RC) ? by : ay;
			dx_s1   <= bw;
			dy_s1   <= bh;
			ex_s1   <= (pair == PAIR_RC) ? ax : bx;
			ey_s1   <= (pair == PAIR_RC) ? ay : by;
			ex2_s1  <= (pair == PAIR_RC) ? rxe : bx + bw;
			ey2_s1  <= (pair == PAIR_RC) ? rye : by + bh;
		end
	end

	// ---------------- stage 2: differences, edge tests
	logic [1:0] pair_s2;
	logic       edge_s2, zero_s2;
	val_t       r_s2, dx_s2, dy_s2;
	val_t       d0x_s2, d0y_s2, d1x_s2, d1y_s2, d2x_s2, d2y_s2, d3x_s2, d3y_s2;

	always_comb begin
		rect_edge_ok =
			(cx_s1 >= rx0_s1 - r_s1 && cx_s1 <= rx1_s1 + r_s1 &&
			 cy_s1 >= ry0_s1 && cy_s1 <= ry1_s1) ||
			(cy_s1 >= ry0_s1 - r_s1 && cy_s1 <= ry1_s1 + r_s1 &&
			 cx_s1 >= rx0_s1 && cx_s1 <= rx1_s1);
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			pair_s2 <= pair_s1;
			edge_s2 <= (pair_s1 == PAIR_RC) && rect_edge_ok;
			zero_s2 <= (dx_s1 == '0) && (dy_s1 == '0);
			r_s2    <= r_s1;
			dx_s2   <= dx_s1;
			dy_s2   <= dy_s1;
			// corner / endpoint deltas: start, end, and rect mixed corners
			d0x_s2  <= ex_s1 - cx_s1;  d0y_s2 <= ey_s1 - cy_s1;
			d1x_s2  <= ex2_s1 - cx_s1; d1y_s2 <= ey2_s1 - cy_s1;
			d2x_s2  <= rxe_s1 - cx_s1; d2y_s2 <= ey_s1 - cy_s1;
			d3x_s2  <= ex_s1 - cx_s1;  d3y_s2 <= rye_s1 - cy_s1;
		end
	end

	// ---------------- stage 3: products
	logic [1:0] pair_s3;
	logic       edge_s3, zero_s3;
	prod_t      rr_s3, c0_s3, c1_s3, c2_s3, c3_s3, dd_s3, dot_s3, crs_s3;
	prod_t      rdx_s3, rdy_s3;

	function automatic prod_t sq(input val_t a, input val_t b);
		return prod_t'(a) * prod_t'(a) + prod_t'(b) * prod_t'(b);
	endfunction

	// e = circle - start = -d0
	always_ff @(posedge clk) begin
		if (adv) begin
			pair_s3 <= pair_s2;
			edge_s3 <= edge_s2;
			zero_s3 <= zero_s2;
			rr_s3   <= prod_t'(r_s2) * prod_t'(r_s2);
			c0_s3   <= sq(d0x_s2, d0y_s2);
			c1_s3   <= sq(d1x_s2, d1y_s2);
			c2_s3   <= sq(d2x_s2, d2y_s2);
			c3_s3   <= sq(d3x_s2, d3y_s2);
			dd_s3   <= sq(dx_s2, dy_s2);
			dot_s3  <= -(prod_t'(d0x_s2) * prod_t'(dx_s2) + prod_t'(d0y_s2) * prod_t'(dy_s2));
			crs_s3  <= -(prod_t'(d0x_s2) * prod_t'(dy_s2) - prod_t'(d0y_s2) * prod_t'(dx_s2));
			rdx_s3  <= prod_t'(r_s2) * prod_t'(dx_s2);
			rdy_s3  <= prod_t'(r_s2) * prod_t'(dy_s2);
		end
	end

	// ---------------- stage 4: compares and split foot-point squares
	logic [1:0] pair_s4;
	logic       near_s4, onseg_s4;
	pp_t        cs_hh_s4, cs_hl_s4, cs_ll_s4;
	pp_t        rx_hh_s4, rx_hl_s4, rx_ll_s4;
	pp_t        ry_hh_s4, ry_hl_s4, ry_ll_s4;
	logic       c0ok, c1ok, c2ok, c3ok;
	hpart_t     crs_h, rdx_h, rdy_h;
	lpart_t     crs_l, rdx_l, rdy_l;

	// signed upper half and unsigned lower half: a = h * 2^LB + l
	function automatic hpart_t hi_part(input prod_t a);
		return hpart_t'(a >>> LB);
	endfunction

	function automatic lpart_t lo_part(input prod_t a);
		return lpart_t'({1'b0, a[LB-1:0]});
	endfunction

	always_comb begin
		c0ok  = c0_s3 <= rr_s3;
		c1ok  = c1_s3 <= rr_s3;
		c2ok  = c2_s3 <= rr_s3;
		c3ok  = c3_s3 <= rr_s3;
		crs_h = hi_part(crs_s3);
		crs_l = lo_part(crs_s3);
		rdx_h = hi_part(rdx_s3);
		rdx_l = lo_part(rdx_s3);
		rdy_h = hi_part(rdy_s3);
		rdy_l = lo_part(rdy_s3);
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			pair_s4 <= pair_s3;
			unique case (pair_s3)
				PAIR_RC: near_s4 <= edge_s3 || c0ok || c1ok || c2ok || c3ok;
				PAIR_CC: near_s4 <= c0ok;
				PAIR_CS: near_s4 <= c0ok || c1ok;
				default: near_s4 <= 1'b0;
			endcase
			onseg_s4 <= !zero_s3 && (dot_s3 >= 0) && (dot_s3 <= dd_s3);
			cs_hh_s4 <= crs_h * crs_h;
			cs_hl_s4 <= crs_h * crs_l;
			cs_ll_s4 <= crs_l * crs_l;
			rx_hh_s4 <= rdx_h * rdx_h;
			rx_hl_s4 <= rdx_h * rdx_l;
			rx_ll_s4 <= rdx_l * rdx_l;
			ry_hh_s4 <= rdy_h * rdy_h;
			ry_hl_s4 <= rdy_h * rdy_l;
			ry_ll_s4 <= rdy_l * rdy_l;
		end
	end

	// ---------------- stage 5: recombine the squares
	logic [1:0] pair_s5;
	logic       near_s5, onseg_s5;
	quad_t      lhs_s5, rhs_s5;

	// h^2 * 2^(2LB) + 2hl * 2^LB + l^2
	function automatic quad_t recombine(input pp_t hh, input pp_t hl, input pp_t ll);
		return (quad_t'(hh) << (2 * LB)) + (quad_t'(hl) << (LB + 1)) + quad_t'(ll);
	endfunction

	always_ff @(posedge clk) begin
		if (adv) begin
			pair_s5  <= pair_s4;
			near_s5  <= near_s4;
			onseg_s5 <= onseg_s4;
			lhs_s5   <= recombine(cs_hh_s4, cs_hl_s4, cs_ll_s4);
			rhs_s5   <= recombine(rx_hh_s4, rx_hl_s4, rx_ll_s4) +
				recombine(ry_hh_s4, ry_hl_s4, ry_ll_s4);
		end
	end

	// ---------------- stage 6: final result register
	logic hit_s6, sup_s6;
	always_ff @(posedge clk) begin
		if (adv) begin
			sup_s6 <= pair_s5 != PAIR_NONE;
			hit_s6 <= near_s5 ||
				(pair_s5 == PAIR_CS && onseg_s5 && lhs_s5 <= rhs_s5);
		end
	end

	assign out_valid      = v_s6;
	assign hit            = hit_s6;
	assign pair_supported = sup_s6;

	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(hit) && $stable(pair_supported))
		else $error("result changed under stall");
	a_hitsup: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && hit |-> pair_supported)
		else $error("hit on unsupported pair");
	a_flow: assert property (@(posedge clk) disable iff (!arst_n)
		!in_stall && v_s5 |=> out_valid)
		else $error("request lost in pipeline");
endmodule

>>> tb/sv/testbench.sv
`timescale 1ns / 1ps
module testbench;
	import spct_pkg::*;

	typedef logic signed [127:0] wide_t;
	typedef logic signed [23:0] coord_t;
	typedef struct {
		logic [1:0] ak;
		coord_t ax, ay, aw, ah;
		logic [1:0] bk;
		coord_t bx, by, bw, bh;
	} pair_req_t;
	typedef struct {
		logic hit;
		logic sup;
	} verdict_t;

	localparam int CYCLE_LIMIT = 400000;
	localparam logic [1:0] KIND_BAD = 2'd3;

	logic clk, arst_n;
	logic cfg_we;
	logic [MARGIN_W-1:0] cfg_wdata;
	logic in_valid, in_stall;
	logic [1:0] a_kind, b_kind;
	coord_t a_x, a_y, a_w, a_h, b_x, b_y, b_w, b_h;
	logic out_valid, out_stall, hit, pair_supported;

	shape_pair_collision_test dut (
		.clk(clk), .arst_n(arst_n), .cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
		.in_valid(in_valid), .in_stall(in_stall),
		.a_kind(a_kind), .a_x(a_x), .a_y(a_y), .a_w(a_w), .a_h(a_h),
		.b_kind(b_kind), .b_x(b_x), .b_y(b_y), .b_w(b_w), .b_h(b_h),
		.out_valid(out_valid), .out_stall(out_stall),
		.hit(hit), .pair_supported(pair_supported)
	);

	verdict_t verdicts_due[$];
	logic [15:0] margin_q88;
	int mismatches;
	int cycles;
	int hold_left;
	bit quiet;

	// ---------------- predictor ----------------
	function automatic wide_t sq_dist(wide_t x1, wide_t y1, wide_t x2, wide_t y2);
		wide_t dx, dy;
		dx = x1 - x2;
		dy = y1 - y2;
		return dx * dx + dy * dy;
	endfunction

	function automatic logic rect_circle_overlap(wide_t rx, wide_t ry, wide_t rw, wide_t rh,
			wide_t cx, wide_t cy, wide_t r);
		wide_t x0, x1, y0, y1, rr;
		x0 = (rx < rx + rw) ? rx : rx + rw;
		x1 = (rx > rx + rw) ? rx : rx + rw;
		y0 = (ry < ry + rh) ? ry : ry + rh;
		y1 = (ry > ry + rh) ? ry : ry + rh;
		rr = r * r;
		if (cx >= x0 - r && cx <= x1 + r && cy >= y0 && cy <= y1) return 1'b1;
		if (cy >= y0 - r && cy <= y1 + r && cx >= x0 && cx <= x1) return 1'b1;
		if (sq_dist(rx, ry, cx, cy) <= rr) return 1'b1;
		if (sq_dist(rx + rw, ry, cx, cy) <= rr) return 1'b1;
		if (sq_dist(rx, ry + rh, cx, cy) <= rr) return 1'b1;
		return sq_dist(rx + rw, ry + rh, cx, cy) <= rr;
	endfunction

	function automatic logic circle_seg_overlap(wide_t px, wide_t py, wide_t r,
			wide_t sx, wide_t sy, wide_t dx, wide_t dy);
		wide_t rr, ex, ey, dd, dotp, crs, lhs, rhs;
		rr = r * r;
		ex = px - sx;
		ey = py - sy;
		if (sq_dist(px, py, sx, sy) <= rr) return 1'b1;
		if (sq_dist(px, py, sx + dx, sy + dy) <= rr) return 1'b1;
		if (dx == 0 && dy == 0) return 1'b0;
		dd = dx * dx + dy * dy;
		dotp = ex * dx + ey * dy;
		if (dotp < 0 || dotp > dd) return 1'b0;
		crs = ex * dy - ey * dx;
		if (crs < 0) crs = -crs;
		if (crs >= (wide_t'(1) <<< 63)) return 1'b0;
		lhs = crs * crs;
		rhs = (r * dx) * (r * dx) + (r * dy) * (r * dy);
		return lhs <= rhs;
	endfunction

	function automatic verdict_t judge_pair(pair_req_t q, logic [15:0] margin);
		verdict_t v;
		logic [1:0] k0, k1;
		wide_t x0, y0, w0, h0, x1, y1, w1, h1;
		v.hit = 1'b0;
		v.sup = 1'b0;
		if (q.ak > q.bk) begin
			k0 = q.bk; k1 = q.ak;
			x0 = q.bx; y0 = q.by; w0 = q.bw; h0 = q.bh;
			x1 = q.ax; y1 = q.ay; w1 = q.aw; h1 = q.ah;
		end else begin
			k0 = q.ak; k1 = q.bk;
			x0 = q.ax; y0 = q.ay; w0 = q.aw; h0 = q.ah;
			x1 = q.bx; y1 = q.by; w1 = q.bw; h1 = q.bh;
		end
		if (k1 == KIND_BAD) return v;
		if (k0 == KIND_RECT && k1 == KIND_CIRCLE) begin
			v.sup = 1'b1;
			v.hit = rect_circle_overlap(x0, y0, w0, h0, x1, y1, w1);
		end else if (k0 == KIND_CIRCLE && k1 == KIND_CIRCLE) begin
			v.sup = 1'b1;
			v.hit = sq_dist(x0, y0, x1, y1) <= (w0 + w1) * (w0 + w1);
		end else if (k0 == KIND_CIRCLE && k1 == KIND_SEG) begin
			v.sup = 1'b1;
			v.hit = circle_seg_overlap(x0, y0, w0 + wide_t'({1'b0, margin}),
				x1, y1, w1, h1);
		end
		return v;
	endfunction

	// ---------------- clock, reset, watchdog ----------------
	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > CYCLE_LIMIT) begin
			$display("DONE: errors detected");
			$finish;
		end
	end

	// ---------------- result receiver ----------------
	int stall_left;
	always @(posedge clk) begin
		if (hold_left > 0) begin
			out_stall <= 1'b1;
			hold_left <= hold_left - 1;
		end else if (stall_left > 0) begin
			out_stall <= 1'b1;
			stall_left <= stall_left - 1;
		end else begin
			out_stall <= 1'b0;
			if (!quiet && $urandom_range(0, 5) == 0) stall_left <= $urandom_range(1, 13);
		end
	end

	always @(posedge clk) begin
		verdict_t e;
		if (arst_n && out_valid && !out_stall) begin
			if (verdicts_due.size() == 0) begin
				mismatches++;
				if (mismatches <= 10) $display("unexpected result hit=%0b sup=%0b",
					hit, pair_supported);
			end else begin
				e = verdicts_due.pop_front();
				if (e.hit !== hit || e.sup !== pair_supported) begin
					mismatches++;
					if (mismatches <= 10)
						$display("mismatch: expected hit=%0b sup=%0b, got hit=%0b sup=%0b",
							e.hit, e.sup, hit, pair_supported);
				end
			end
		end
	end

	// ---------------- request driver ----------------
	task automatic send_pair(pair_req_t q);
		if (!quiet && $urandom_range(0, 4) == 0) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 13)) @(posedge clk);
		end
		in_valid <= 1'b1;
		a_kind <= q.ak; a_x <= q.ax; a_y <= q.ay; a_w <= q.aw; a_h <= q.ah;
		b_kind <= q.bk; b_x <= q.bx; b_y <= q.by; b_w <= q.bw; b_h <= q.bh;
		@(posedge clk);
		while (in_stall) @(posedge clk);
		verdicts_due.push_back(judge_pair(q, margin_q88));
	endtask

	task automatic drain;
		in_valid <= 1'b0;
		while (verdicts_due.size() != 0) @(posedge clk);
		repeat (10) @(posedge clk);
	endtask

	task automatic set_margin(logic [15:0] m);
		drain();
		cfg_we <= 1'b1;
		cfg_wdata <= m;
		@(posedge clk);
		cfg_we <= 1'b0;
		margin_q88 = m;
	endtask

	function automatic pair_req_t mk(logic [1:0] ak, int ax, int ay, int aw, int ah,
			logic [1:0] bk, int bx, int by, int bw, int bh);
		pair_req_t q;
		q.ak = ak; q.ax = coord_t'(ax); q.ay = coord_t'(ay);
		q.aw = coord_t'(aw); q.ah = coord_t'(ah);
		q.bk = bk; q.bx = coord_t'(bx); q.by = coord_t'(by);
		q.bw = coord_t'(bw); q.bh = coord_t'(bh);
		return q;
	endfunction

	// nearby values so that hits and misses both occur
	function automatic int near_val(int span);
		return int'($urandom_range(0, 2 * span)) - span;
	endfunction

	function automatic pair_req_t random_pair();
		pair_req_t q;
		int sel;
		sel = $urandom_range(0, 19);
		if (sel < 3) begin
			q.ak = 2'($urandom); q.ax = coord_t'($urandom); q.ay = coord_t'($urandom);
			q.aw = coord_t'($urandom); q.ah = coord_t'($urandom);
			q.bk = 2'($urandom); q.bx = coord_t'($urandom); q.by = coord_t'($urandom);
			q.bw = coord_t'($urandom); q.bh = coord_t'($urandom);
			return q;
		end
		q.ak = 2'((sel < 17) ? $urandom_range(0, 2) : $urandom_range(0, 3));
		q.bk = 2'((sel < 17) ? $urandom_range(0, 2) : $urandom_range(0, 3));
		if (sel < 10 && q.ak != KIND_CIRCLE && q.bk != KIND_CIRCLE) q.ak = KIND_CIRCLE;
		q.ax = coord_t'(near_val(6000)); q.ay = coord_t'(near_val(6000));
		q.aw = coord_t'(near_val(3000)); q.ah = coord_t'(near_val(3000));
		q.bx = coord_t'(near_val(6000)); q.by = coord_t'(near_val(6000));
		q.bw = coord_t'(near_val(3000)); q.bh = coord_t'(near_val(3000));
		if ($urandom_range(0, 5) == 0) q.bh = '0;
		else if ($urandom_range(0, 5) == 0) q.bw = '0;
		return q;
	endfunction

	// ---------------- tests ----------------
	localparam int PMAX = 8388607;
	localparam int PMIN = -8388608;

	task automatic test_directed;
		send_pair(mk(KIND_CIRCLE, 0, 0, 256, 0, KIND_CIRCLE, 512, 0, 256, 0));
		send_pair(mk(KIND_CIRCLE, 0, 0, 256, 0, KIND_CIRCLE, 513, 0, 256, 0));
		send_pair(mk(KIND_CIRCLE, PMAX, PMAX, PMAX, PMAX, KIND_CIRCLE, PMIN, PMIN, PMIN, PMIN));
		send_pair(mk(KIND_RECT, 0, 0, 1000, 500, KIND_CIRCLE, 1100, 250, 100, 0));
		send_pair(mk(KIND_CIRCLE, 1100, 600, 100, 0, KIND_RECT, 0, 0, 1000, 500));
		send_pair(mk(KIND_RECT, 1000, 500, -1000, -500, KIND_CIRCLE, 1070, 570, 100, 0));
		send_pair(mk(KIND_RECT, 0, 0, 1000, 500, KIND_CIRCLE, 1050, 250, -100, 0));
		send_pair(mk(KIND_RECT, PMIN, PMIN, PMAX, PMAX, KIND_CIRCLE, PMAX, PMAX, PMAX, PMIN));
		send_pair(mk(KIND_RECT, 0, 0, 10, 10, KIND_RECT, 0, 0, 10, 10));
		send_pair(mk(KIND_SEG, 0, 0, 100, 0, KIND_SEG, 0, 0, 100, 0));
		send_pair(mk(KIND_RECT, 0, 0, 100, 100, KIND_SEG, 0, 0, 100, 0));
		send_pair(mk(KIND_BAD, 0, 0, 100, 0, KIND_CIRCLE, 0, 0, 100, 0));
		send_pair(mk(KIND_CIRCLE, 0, 0, 100, 0, KIND_BAD, 0, 0, 100, 0));
		send_pair(mk(KIND_SEG, 500, 500, 0, 0, KIND_CIRCLE, 500, 1000, 100, 0));
		send_pair(mk(KIND_CIRCLE, 300, 1000, 100, 0, KIND_SEG, 0, 0, 0, 3000));
		send_pair(mk(KIND_CIRCLE, 1000, 1500, 100, 0, KIND_SEG, 0, 1000, 3000, 0));
		send_pair(mk(KIND_CIRCLE, 1000, 0, 400, 0, KIND_SEG, 0, 0, 2000, 2000));
		send_pair(mk(KIND_CIRCLE, 1000, 0, 200, 0, KIND_SEG, 0, 0, 2000, 2000));
		send_pair(mk(KIND_CIRCLE, 3000, 3000, 100, 0, KIND_SEG, 0, 0, 2000, 2000));
		send_pair(mk(KIND_CIRCLE, PMIN, PMAX, PMAX, 0, KIND_SEG, PMAX, PMIN, PMIN, PMAX));
		send_pair(mk(KIND_CIRCLE, PMIN, PMIN, PMIN, 0, KIND_SEG, PMAX, PMAX, PMIN, PMIN));
	endtask

	task automatic test_random(int n);
		repeat (n) send_pair(random_pair());
	endtask

	task automatic test_margins;
		set_margin(16'd0);
		test_random(60);
		set_margin(16'hffff);
		test_random(60);
		set_margin(16'($urandom));
		test_random(60);
		set_margin(16'd1280);
	endtask

	// receiver holds off while requests keep coming, so the pipe backs up
	task automatic test_backpressure;
		hold_left = 80;
		repeat (30) send_pair(random_pair());
	endtask

	initial begin
		arst_n = 1'b0;
		cfg_we = 1'b0; cfg_wdata = '0;
		in_valid = 1'b0; out_stall = 1'b0;
		a_kind = '0; a_x = '0; a_y = '0; a_w = '0; a_h = '0;
		b_kind = '0; b_x = '0; b_y = '0; b_w = '0; b_h = '0;
		margin_q88 = MARGIN_RESET;
		mismatches = 0; cycles = 0; hold_left = 0; stall_left = 0; quiet = 1'b0;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_directed();
		test_random(320);
		test_margins();
		test_backpressure();
		quiet = 1'b1;
		test_random(100);
		drain();
		if (mismatches == 0 && verdicts_due.size() == 0) begin
			$display("DONE: 0 errors");
		end else begin
			$display("DONE: errors detected");
		end
		$finish;
	end
endmodule

>>> shape_pair_collision_test.f
sv/spct_pkg.sv
sv/shape_pair_collision_test.sv
tb/sv/testbench.sv
